// ----- src/bedm_pkg.sv -----
// Shared types and constants of the bitap edit distance matcher.
package bedm_pkg;

    // Field widths of the transaction payloads and the configuration port
    localparam int TEXT_W     = 8;
    localparam int DIST_W     = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int PLEN_W     = 5;
    localparam int ERR_W      = 3;
    localparam int PAT_BYTES  = 16;

    // Input operation codes
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_FEED    = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_PATTERN_LEN  = 3'd2,
        REG_MAX_ERRORS   = 3'd3,
        REG_TRANSPOSE    = 3'd4
    } cfg_index_t;

    // Configuration register file contents
    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_low;
        logic [CFG_DATA_W-1:0] pattern_high;
        logic [PLEN_W-1:0]     pattern_length;
        logic [ERR_W-1:0]      max_errors;
        logic                  transpositions_on;
    } cfg_t;

    // One result transaction
    typedef struct packed {
        logic              alive;
        logic              full_match;
        logic [DIST_W-1:0] distance;
    } result_t;

endpackage

// ----- src/bedm_item_if.sv -----
// Input channel: operation and text byte with valid/ready handshake.
interface bedm_item_if;
    import bedm_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [TEXT_W-1:0] text_char;

    modport source (output valid, output op, output text_char, input ready);
    modport sink   (input valid, input op, input text_char, output ready);
endinterface

// ----- src/bedm_result_if.sv -----
// Output channel: match status with valid/ready handshake.
interface bedm_result_if;
    import bedm_pkg::*;

    logic              valid;
    logic              ready;
    logic              alive;
    logic              full_match;
    logic [DIST_W-1:0] distance;

    modport source (output valid, output alive, output full_match, output distance,
                    input ready);
    modport sink   (input valid, input alive, input full_match, input distance,
                    output ready);
endinterface

// ----- src/bedm_step.sv -----
// Next-state and result logic for one restart or text byte.
module bedm_step #(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_ERRORS  = 4,
    parameter int NUM_LVL     = MAX_ERRORS + 1,
    parameter int LVL_W       = $clog2(MAX_ERRORS + 2)
) (
    input  logic                            op,
    input  logic [bedm_pkg::TEXT_W-1:0]     text_char,
    input  bedm_pkg::cfg_t                  cfg,
    input  logic [MAX_PATTERN-1:0]          match_rows      [NUM_LVL],
    input  logic [MAX_PATTERN-1:0]          prev_rows       [NUM_LVL],
    input  logic [MAX_PATTERN-1:0]          prev_char_mask,
    input  logic [LVL_W-1:0]                live_level,
    input  logic [LVL_W-1:0]                prev_live_level,
    input  logic [LVL_W-1:0]                text_pos,
    output logic [MAX_PATTERN-1:0]          match_rows_next [NUM_LVL],
    output logic [MAX_PATTERN-1:0]          prev_rows_next  [NUM_LVL],
    output logic [MAX_PATTERN-1:0]          prev_char_mask_next,
    output logic [LVL_W-1:0]                live_level_next,
    output logic [LVL_W-1:0]                prev_live_level_next,
    output logic [LVL_W-1:0]                text_pos_next,
    output bedm_pkg::result_t               res
);
    import bedm_pkg::*;

    localparam int PW = $clog2(MAX_PATTERN + 1);
    localparam logic [LVL_W-1:0] POS_SAT = LVL_W'(MAX_ERRORS + 1);
    localparam logic [MAX_PATTERN-1:0] BIT0 = MAX_PATTERN'(1);
    localparam logic [MAX_PATTERN-1:0] BIT1 = MAX_PATTERN'(2);

    logic [PW-1:0]          m_eff;
    logic [LVL_W-1:0]       k_eff;
    logic [MAX_PATTERN-1:0] len_mask;
    logic [MAX_PATTERN-1:0] last_bit;
    logic [MAX_PATTERN-1:0] smap;
    logic [MAX_PATTERN-1:0] fresh [NUM_LVL];
    logic [LVL_W-1:0]       live_scan;
    logic [127:0]           pattern_bytes;

    // Clamp the configured length and error bound
    always_comb
    begin
        if (cfg.pattern_length == '0)
        begin
            m_eff = PW'(1);
        end
        else if (cfg.pattern_length > MAX_PATTERN)
        begin
            m_eff = PW'(MAX_PATTERN);
        end
        else
        begin
            m_eff = PW'(cfg.pattern_length);
        end
        if (cfg.max_errors > MAX_ERRORS)
        begin
            k_eff = LVL_W'(MAX_ERRORS);
        end
        else
        begin
            k_eff = LVL_W'(cfg.max_errors);
        end
    end

    assign pattern_bytes = {cfg.pattern_high, cfg.pattern_low};
    assign last_bit      = len_mask & ~(len_mask >> 1);

    // Build the length mask and the character match map, one lane per pattern byte
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_lane
        assign len_mask[i] = (i < m_eff);
        if (i < PAT_BYTES)
        begin : g_stored
            assign smap[i] = len_mask[i] && (pattern_bytes[8*i +: 8] == text_char);
        end
        else
        begin : g_zero
            assign smap[i] = len_mask[i] && (text_char == '0);
        end
    end

    // Advance the rows one error level at a time, then add transpositions
    always_comb
    begin
        logic [MAX_PATTERN-1:0] t;
        logic [MAX_PATTERN-1:0] lower_row;
        logic [MAX_PATTERN-1:0] lower_fresh;
        logic [MAX_PATTERN-1:0] lower_prev;
        t           = '0;
        lower_row   = '0;
        lower_fresh = '0;
        lower_prev  = '0;
        for (int d = 0; d < NUM_LVL; d++)
        begin
            fresh[d] = '0;
            if (LVL_W'(d) >= live_level && LVL_W'(d) <= k_eff)
            begin
                t = match_rows[d] << 1;
                if (text_pos <= LVL_W'(d))
                begin
                    t = t | BIT0;
                end
                fresh[d] = t & smap;
                if (LVL_W'(d) > live_level)
                begin
                    t = ((lower_row | lower_fresh) << 1) | lower_row;
                    if (text_pos < LVL_W'(d))
                    begin
                        t = t | BIT0;
                    end
                    fresh[d] = fresh[d] | (t & len_mask);
                end
            end
            // The level above sees this row before any swap bits are added
            lower_fresh = fresh[d];
            if (cfg.transpositions_on && text_pos != '0 && d > 0 &&
                LVL_W'(d) > prev_live_level && LVL_W'(d) <= k_eff)
            begin
                t = lower_prev << 2;
                if (text_pos <= LVL_W'(d) && m_eff > PW'(1))
                begin
                    t = t | BIT1;
                end
                t = t & prev_char_mask & (smap << 1);
                fresh[d] = fresh[d] | (t & len_mask);
            end
            lower_row   = match_rows[d];
            lower_prev  = prev_rows[d];
        end
    end

    // Raise the lowest live level past leading empty rows
    always_comb
    begin
        live_scan = live_level;
        for (int d = 0; d < NUM_LVL; d++)
        begin
            if (LVL_W'(d) >= live_level && LVL_W'(d) <= k_eff && live_scan == LVL_W'(d) &&
                text_pos >= LVL_W'(d) && fresh[d] == '0)
            begin
                live_scan = LVL_W'(d + 1);
            end
        end
    end

    // Select restart or feed state
    always_comb
    begin
        if (op == OP_FEED)
        begin
            for (int d = 0; d < NUM_LVL; d++)
            begin
                match_rows_next[d] = fresh[d];
                prev_rows_next[d]  = cfg.transpositions_on ? match_rows[d] : prev_rows[d];
            end
            prev_char_mask_next  = smap;
            live_level_next      = live_scan;
            prev_live_level_next = live_level;
            text_pos_next        = (text_pos < POS_SAT) ? text_pos + LVL_W'(1) : text_pos;
        end
        else
        begin
            for (int d = 0; d < NUM_LVL; d++)
            begin
                match_rows_next[d] = MAX_PATTERN'((32'd1 << d) - 32'd1);
                prev_rows_next[d]  = '0;
            end
            prev_char_mask_next  = '0;
            live_level_next      = '0;
            prev_live_level_next = '0;
            text_pos_next        = '0;
        end
    end

    // Derive match status from the updated rows
    always_comb
    begin
        logic             full;
        logic [LVL_W-1:0] least_level;
        full        = 1'b0;
        least_level = '0;
        for (int d = 0; d < NUM_LVL; d++)
        begin
            if (LVL_W'(d) == k_eff)
            begin
                full = |(match_rows_next[d] & last_bit);
            end
            if (LVL_W'(d) <= k_eff && !(|(match_rows_next[d] & last_bit)))
            begin
                least_level = LVL_W'(d + 1);
            end
        end
        res.full_match = full;
        res.distance   = full ? DIST_W'(least_level) : '0;
        res.alive      = (live_level_next <= k_eff) ||
                         (cfg.transpositions_on && prev_live_level_next < k_eff);
    end

endmodule

// ----- src/bitap_edit_distance_matcher_unit.sv -----
// Top level of the bitap approximate matcher: config, state, result queue.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------
//  item     | in  | valid / ready | op, text_char
//  result   | out | valid / ready | alive, full_match, distance
//  cfg      | in  | cfg_wr_en     | cfg_index, cfg_data (write only)
//
// One item per cycle while item.ready is high; each result is registered into the queue head,
// or into its tail while the head holds a result that is not taken. All levels update together.
// A two-entry result queue lets item.ready stay high while one result waits.
// Reset loads the initial rows and the configuration defaults; no clearing pass.
module bitap_edit_distance_matcher_unit #(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_ERRORS  = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bedm_item_if.sink                         item,
    bedm_result_if.source                     result,
    input  logic                              cfg_wr_en,
    input  logic [bedm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bedm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bedm_pkg::*;

    localparam int NUM_LVL = MAX_ERRORS + 1;
    localparam int LVL_W   = $clog2(MAX_ERRORS + 2);
    localparam logic [LVL_W-1:0] POS_SAT = LVL_W'(MAX_ERRORS + 1);

    cfg_t                   cfg_reg;
    logic [MAX_PATTERN-1:0] match_rows_reg      [NUM_LVL];
    logic [MAX_PATTERN-1:0] prev_rows_reg       [NUM_LVL];
    logic [MAX_PATTERN-1:0] prev_char_mask_reg;
    logic [LVL_W-1:0]       live_level_reg;
    logic [LVL_W-1:0]       prev_live_level_reg;
    logic [LVL_W-1:0]       text_pos_reg;

    logic [MAX_PATTERN-1:0] match_rows_next     [NUM_LVL];
    logic [MAX_PATTERN-1:0] prev_rows_next      [NUM_LVL];
    logic [MAX_PATTERN-1:0] prev_char_mask_next;
    logic [LVL_W-1:0]       live_level_next;
    logic [LVL_W-1:0]       prev_live_level_next;
    logic [LVL_W-1:0]       text_pos_next;
    result_t                step_res;

    result_t                head_reg;
    result_t                head_next;
    result_t                tail_reg;
    result_t                tail_next;
    logic                   head_valid_reg;
    logic                   head_valid_next;
    logic                   tail_valid_reg;
    logic                   tail_valid_next;

    logic                   accept;
    logic                   pop;

    assign accept      = item.valid && item.ready;
    assign pop         = result.valid && result.ready;
    assign item.ready  = !tail_valid_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low       <= '0;
            cfg_reg.pattern_high      <= '0;
            cfg_reg.pattern_length    <= PLEN_W'(1);
            cfg_reg.max_errors        <= '0;
            cfg_reg.transpositions_on <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:  cfg_reg.pattern_low       <= cfg_data;
                REG_PATTERN_HIGH: cfg_reg.pattern_high      <= cfg_data;
                REG_PATTERN_LEN:  cfg_reg.pattern_length    <= cfg_data[PLEN_W-1:0];
                REG_MAX_ERRORS:   cfg_reg.max_errors        <= cfg_data[ERR_W-1:0];
                REG_TRANSPOSE:    cfg_reg.transpositions_on <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Compute the next match state and the result
    bedm_step #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_ERRORS  (MAX_ERRORS),
        .NUM_LVL     (NUM_LVL),
        .LVL_W       (LVL_W)
    ) u_step (
        .op                   (item.op),
        .text_char            (item.text_char),
        .cfg                  (cfg_reg),
        .match_rows           (match_rows_reg),
        .prev_rows            (prev_rows_reg),
        .prev_char_mask       (prev_char_mask_reg),
        .live_level           (live_level_reg),
        .prev_live_level      (prev_live_level_reg),
        .text_pos             (text_pos_reg),
        .match_rows_next      (match_rows_next),
        .prev_rows_next       (prev_rows_next),
        .prev_char_mask_next  (prev_char_mask_next),
        .live_level_next      (live_level_next),
        .prev_live_level_next (prev_live_level_next),
        .text_pos_next        (text_pos_next),
        .res                  (step_res)
    );

    // Advance match state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_LVL; d++)
            begin
                match_rows_reg[d] <= MAX_PATTERN'((32'd1 << d) - 32'd1);
                prev_rows_reg[d]  <= '0;
            end
            prev_char_mask_reg  <= '0;
            live_level_reg      <= '0;
            prev_live_level_reg <= '0;
            text_pos_reg        <= '0;
        end
        else if (accept)
        begin
            for (int d = 0; d < NUM_LVL; d++)
            begin
                match_rows_reg[d] <= match_rows_next[d];
                prev_rows_reg[d]  <= prev_rows_next[d];
            end
            prev_char_mask_reg  <= prev_char_mask_next;
            live_level_reg      <= live_level_next;
            prev_live_level_reg <= prev_live_level_next;
            text_pos_reg        <= text_pos_next;
        end
    end

    // Steer results through the two-entry queue
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        if (pop)
        begin
            if (tail_valid_reg)
            begin
                head_next       = tail_reg;
                tail_valid_next = 1'b0;
            end
            else if (accept)
            begin
                head_next = step_res;
            end
            else
            begin
                head_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (head_valid_reg)
            begin
                tail_next       = step_res;
                tail_valid_next = 1'b1;
            end
            else
            begin
                head_next       = step_res;
                head_valid_next = 1'b1;
            end
        end
    end

    // Hold queue occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    // Hold queue payload
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    // Drive the result channel
    assign result.valid      = head_valid_reg;
    assign result.alive      = head_reg.alive;
    assign result.full_match = head_reg.full_match;
    assign result.distance   = head_reg.distance;

    // Queue never holds a second entry without a first
    assert property (@(posedge clk) disable iff (!rst_n) tail_valid_reg |-> head_valid_reg)
        else $error("result queue tail valid without head");

    // Every accepted transaction leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> result.valid)
        else $error("accepted transaction produced no result");

    // Restart clears the live level and text position
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.op == OP_RESTART) |=> (live_level_reg == '0 && text_pos_reg == '0))
        else $error("restart did not clear position state");

    // Feed advances the text position until it saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.op == OP_FEED && text_pos_reg < POS_SAT)
        |=> (text_pos_reg == $past(text_pos_reg) + LVL_W'(1)))
        else $error("text position did not advance");

endmodule
